// ===== src/bxq_pkg.sv =====
`default_nettype none
package bxq_pkg;

  localparam int KIND_W   = 3;
  localparam int KEY_W    = 31;
  localparam int STATUS_W = 2;

  localparam logic [KIND_W-1:0] KIND_INSERT  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_MIN     = 3'd1;
  localparam logic [KIND_W-1:0] KIND_MIN_DEL = 3'd2;
  localparam logic [KIND_W-1:0] KIND_MAX     = 3'd3;
  localparam logic [KIND_W-1:0] KIND_MAX_DEL = 3'd4;
  localparam logic [KIND_W-1:0] KIND_CLEAR   = 3'd5;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_START,
    OP_CLEAR,
    OP_RD_LINK,
    OP_RD_PCNT,
    OP_PICK,
    OP_DEC,
    OP_INS_CHK,
    OP_INS_WR,
    OP_DONE
  } dp_op_t;

  typedef struct packed {
    dp_op_t                op;
    logic [STATUS_W-1:0]   done_status;
  } dp_cmd_t;

  typedef struct packed {
    logic is_insert;
    logic is_query;
    logic is_clear;
    logic want_del;
    logic set_empty;
    logic set_full;
    logic last_level;
    logic nx_zero;
    logic out_free;
  } dp_sts_t;

endpackage
`default_nettype wire

// ===== src/bxq_ram.sv =====
`default_nettype none
module bxq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// ===== src/bxq_dp.sv =====
`default_nettype none
module bxq_dp import bxq_pkg::*; #(
  parameter int KEY_BITS   = 31,
  parameter int POOL_NODES = 8192,
  parameter int COUNT_BITS = 24
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire dp_cmd_t             cmd,
  input  wire logic [KIND_W-1:0]   in_kind,
  input  wire logic [KEY_W-1:0]    in_key,
  input  wire logic                out_ready,
  output logic                     out_valid,
  output logic [KEY_W-1:0]         out_xor,
  output logic [STATUS_W-1:0]      out_status,
  output dp_sts_t                  sts
);

  localparam int NW = $clog2(POOL_NODES);
  localparam int LW = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;

  logic [KIND_W-1:0]     kind_r;
  logic [KEY_BITS-1:0]   key_r;
  logic [KEY_BITS-1:0]   res_r, res_nxt;
  logic [LW-1:0]         level_r;
  logic [NW-1:0]         cur_r;
  logic [NW-1:0]         nx_r;
  logic                  alloc_r;
  logic [2*NW-1:0]       links_r;
  logic [NW-1:0]         root_r [2];
  logic [NW:0]           next_free_r;
  logic [COUNT_BITS-1:0] total_r;
  logic                  out_valid_r;
  logic [KEY_W-1:0]      out_xor_r;
  logic [STATUS_W-1:0]   out_status_r;

  logic                  link_we, link_re, cnt_we, cnt_re;
  logic [NW-1:0]         link_waddr, cnt_waddr, cnt_raddr;
  logic [2*NW-1:0]       link_wdata, link_rdata, links_w;
  logic [COUNT_BITS-1:0] cnt_wdata, cnt_rdata;

  logic                  is_query, want_max, want_del;
  logic                  kb, pref, take_bit, usable;
  logic [NW-1:0]         pchild, nx, ins_child;

  assign is_query = (kind_r inside {[KIND_MIN:KIND_MAX_DEL]});
  assign want_max = (kind_r == KIND_MAX) || (kind_r == KIND_MAX_DEL);
  assign want_del = (kind_r == KIND_MIN_DEL) || (kind_r == KIND_MAX_DEL);

  assign links_w   = (cur_r == '0) ? {root_r[1], root_r[0]} : link_rdata;
  assign kb        = key_r[level_r];
  assign pref      = kb ^ want_max;
  assign pchild    = pref ? links_r[2*NW-1:NW] : links_r[NW-1:0];
  assign usable    = (pchild != '0) && (cnt_rdata != '0);
  assign take_bit  = usable ? pref : ~pref;
  assign nx        = take_bit ? links_r[2*NW-1:NW] : links_r[NW-1:0];
  assign ins_child = kb ? links_w[2*NW-1:NW] : links_w[NW-1:0];

  always_comb begin
    res_nxt = res_r;
    res_nxt[level_r] = take_bit ^ kb;
  end

  always_comb begin
    link_we    = 1'b0;
    link_waddr = cur_r;
    link_wdata = links_r;
    link_re    = 1'b0;
    cnt_we     = 1'b0;
    cnt_waddr  = nx_r;
    cnt_wdata  = cnt_rdata + COUNT_BITS'(1);
    cnt_re     = 1'b0;
    cnt_raddr  = nx;
    case (cmd.op)
      OP_RD_LINK: begin
        link_re = 1'b1;
      end
      OP_RD_PCNT: begin
        cnt_re    = 1'b1;
        cnt_raddr = (pref ^ 1'b0) ? links_w[2*NW-1:NW] : links_w[NW-1:0];
      end
      OP_PICK: begin
        cnt_re = 1'b1;
      end
      OP_DEC: begin
        cnt_we    = (cnt_rdata != '0);
        cnt_wdata = cnt_rdata - COUNT_BITS'(1);
      end
      OP_INS_CHK: begin
        cnt_re     = 1'b1;
        cnt_raddr  = ins_child;
        link_we    = (ins_child == '0);
        link_waddr = next_free_r[NW-1:0];
        link_wdata = '0;
      end
      OP_INS_WR: begin
        if (alloc_r) begin
          cnt_wdata = COUNT_BITS'(1);
          link_we   = (cur_r != '0);
          if (kb) begin
            link_wdata = {nx_r, links_r[NW-1:0]};
          end else begin
            link_wdata = {links_r[2*NW-1:NW], nx_r};
          end
        end
        cnt_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  bxq_ram #(.WIDTH(2*NW), .DEPTH(POOL_NODES)) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .re    (link_re),
    .raddr (cur_r),
    .rdata (link_rdata)
  );

  bxq_ram #(.WIDTH(COUNT_BITS), .DEPTH(POOL_NODES)) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .re    (cnt_re),
    .raddr (cnt_raddr),
    .rdata (cnt_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      root_r[0]    <= '0;
      root_r[1]    <= '0;
      next_free_r  <= (NW+1)'(1);
      total_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cmd.op == OP_DONE) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (cmd.op)
        OP_CLEAR: begin
          root_r[0]   <= '0;
          root_r[1]   <= '0;
          next_free_r <= (NW+1)'(1);
          total_r     <= '0;
        end
        OP_INS_CHK: begin
          if (ins_child == '0) begin
            next_free_r <= next_free_r + (NW+1)'(1);
          end
        end
        OP_INS_WR: begin
          if (alloc_r && (cur_r == '0)) begin
            root_r[kb] <= nx_r;
          end
        end
        OP_DONE: begin
          if (cmd.done_status == STATUS_OK) begin
            if (kind_r == KIND_INSERT) begin
              total_r <= total_r + COUNT_BITS'(1);
            end else if (is_query && want_del) begin
              total_r <= total_r - COUNT_BITS'(1);
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_START: begin
        kind_r  <= in_kind;
        key_r   <= KEY_BITS'(in_key);
        res_r   <= '0;
        level_r <= LW'(KEY_BITS-1);
        cur_r   <= '0;
      end
      OP_RD_PCNT: begin
        links_r <= links_w;
      end
      OP_PICK: begin
        res_r <= res_nxt;
        if (nx != '0) begin
          cur_r   <= nx;
          nx_r    <= nx;
          level_r <= level_r - LW'(1);
        end
      end
      OP_INS_CHK: begin
        links_r <= links_w;
        alloc_r <= (ins_child == '0);
        nx_r    <= (ins_child == '0) ? next_free_r[NW-1:0] : ins_child;
      end
      OP_INS_WR: begin
        cur_r   <= nx_r;
        level_r <= level_r - LW'(1);
      end
      OP_DONE: begin
        out_status_r <= cmd.done_status;
        out_xor_r    <= (cmd.done_status == STATUS_OK && is_query) ? KEY_W'(res_r) : '0;
      end
      default: begin
      end
    endcase
  end

  assign out_valid  = out_valid_r;
  assign out_xor    = out_xor_r;
  assign out_status = out_status_r;

  always_comb begin
    sts.is_insert  = (kind_r == KIND_INSERT);
    sts.is_query   = is_query;
    sts.is_clear   = (kind_r == KIND_CLEAR);
    sts.want_del   = want_del;
    sts.set_empty  = (total_r == '0);
    sts.set_full   = (total_r == '1) ||
                     (({1'b0, next_free_r} + (NW+2)'(KEY_BITS)) > (NW+2)'(POOL_NODES));
    sts.last_level = (level_r == '0);
    sts.nx_zero    = (nx == '0);
    sts.out_free   = !out_valid_r || out_ready;
  end

endmodule
`default_nettype wire

// ===== src/bxq_ctrl.sv =====
`default_nettype none
module bxq_ctrl import bxq_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire dp_sts_t sts,
  output dp_cmd_t      cmd
);

  typedef enum logic [7:0] {
    ST_IDLE     = 8'b0000_0001,
    ST_DECODE   = 8'b0000_0010,
    ST_RD_LINK  = 8'b0000_0100,
    ST_RD_PCNT  = 8'b0000_1000,
    ST_PICK     = 8'b0001_0000,
    ST_DEC      = 8'b0010_0000,
    ST_INS      = 8'b0100_0000,
    ST_DONE     = 8'b1000_0000
  } state_t;

  state_t              state_r, state_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic                last_r, last_nxt;
  logic                ins_wr_r, ins_wr_nxt;

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt       = state_r;
    status_nxt      = status_r;
    last_nxt        = last_r;
    ins_wr_nxt      = ins_wr_r;
    cmd.op          = OP_NONE;
    cmd.done_status = status_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.op     = OP_START;
          status_nxt = STATUS_OK;
          state_nxt  = ST_DECODE;
        end
      end
      ST_DECODE: begin
        state_nxt = ST_DONE;
        if (sts.is_insert) begin
          if (sts.set_full) begin
            status_nxt = STATUS_FULL;
          end else begin
            state_nxt = ST_RD_LINK;
          end
        end else if (sts.is_query) begin
          if (sts.set_empty) begin
            status_nxt = STATUS_EMPTY;
          end else begin
            state_nxt = ST_RD_LINK;
          end
        end else if (sts.is_clear) begin
          cmd.op = OP_CLEAR;
        end
      end
      ST_RD_LINK: begin
        cmd.op     = OP_RD_LINK;
        ins_wr_nxt = 1'b0;
        state_nxt  = sts.is_insert ? ST_INS : ST_RD_PCNT;
      end
      ST_RD_PCNT: begin
        cmd.op    = OP_RD_PCNT;
        state_nxt = ST_PICK;
      end
      ST_PICK: begin
        cmd.op = OP_PICK;
        if (sts.nx_zero) begin
          state_nxt = ST_DONE;
        end else if (sts.want_del) begin
          last_nxt  = sts.last_level;
          state_nxt = ST_DEC;
        end else begin
          state_nxt = sts.last_level ? ST_DONE : ST_RD_LINK;
        end
      end
      ST_DEC: begin
        cmd.op    = OP_DEC;
        state_nxt = last_r ? ST_DONE : ST_RD_LINK;
      end
      ST_INS: begin
        if (!ins_wr_r) begin
          cmd.op     = OP_INS_CHK;
          ins_wr_nxt = 1'b1;
        end else begin
          cmd.op    = OP_INS_WR;
          state_nxt = sts.last_level ? ST_DONE : ST_RD_LINK;
        end
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.op    = OP_DONE;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      status_r <= STATUS_OK;
      last_r   <= 1'b0;
      ins_wr_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      status_r <= status_nxt;
      last_r   <= last_nxt;
      ins_wr_r <= ins_wr_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== src/binary_trie_xor_query_unit.sv =====
// channel | dir | tdata                      | tuser
// in_     | in  | [30:0] key, [31] zero      | [2:0] kind
// out_    | out | [30:0] xor_value, [31] 0   | [1:0] status
// One operation at a time. Insert, per level: link read, child check, write.
// Query: link read, count read, pick, decrement on delete; clear/errors: no walk.
// Per level the trie walk waits on registered reads of the link and count RAMs.
// rst_n is synchronous; reset empties the set at once, no clearing pass.
// The result register frees the walk; a stalled result holds the next one back.
`default_nettype none
module binary_trie_xor_query_unit import bxq_pkg::*; #(
  parameter int KEY_BITS   = 31,
  parameter int POOL_NODES = 8192,
  parameter int COUNT_BITS = 24
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // [30:0] key
  input  wire logic [2:0]  in_tuser,   // [2:0] kind
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // [30:0] xor_value
  output logic [1:0]       out_tuser   // [1:0] status
);

  dp_cmd_t          cmd;
  dp_sts_t          sts;
  logic [KEY_W-1:0] out_xor;

  bxq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bxq_dp #(
    .KEY_BITS   (KEY_BITS),
    .POOL_NODES (POOL_NODES),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_kind    (in_tuser),
    .in_key     (in_tdata[KEY_W-1:0]),
    .out_ready  (out_tready),
    .out_valid  (out_tvalid),
    .out_xor    (out_xor),
    .out_status (out_tuser),
    .sts        (sts)
  );

  assign out_tdata = {1'b0, out_xor};

endmodule
`default_nettype wire

// ===== src/bxq_checker.sv =====
`default_nettype none
module bxq_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic [31:0] in_tdata,
  input wire logic [2:0]  in_tuser,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [31:0] out_tdata,
  input wire logic [1:0]  out_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser != 2'd3)
    else $error("bad status code");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != 2'd0 |-> out_tdata == 32'd0)
    else $error("nonzero xor with error status");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second beat taken during a walk");

endmodule

bind binary_trie_xor_query_unit bxq_checker u_bxq_checker (.*);
`default_nettype wire
